/* hw/rtl/mrs_pkg.sv */
package mrs_pkg;

    // Configuration register indexes.
    typedef logic [3:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MARKER_VALUE  = 4'd0;
    localparam t_cfg_idx CFG_MIN_RUN_BYTES = 4'd1;
    localparam t_cfg_idx CFG_SKIP_A_START  = 4'd2;
    localparam t_cfg_idx CFG_SKIP_A_END    = 4'd3;
    localparam t_cfg_idx CFG_SKIP_B_START  = 4'd4;
    localparam t_cfg_idx CFG_SKIP_B_END    = 4'd5;
    localparam t_cfg_idx CFG_SKIP_C_START  = 4'd6;
    localparam t_cfg_idx CFG_SKIP_C_END    = 4'd7;

    // Register values after reset.
    localparam logic [31:0] RST_MARKER_VALUE  = 32'hA5A5_A5A5;
    localparam logic [32:0] RST_MIN_RUN_BYTES = 33'h0_0000_1000;
    localparam logic [31:0] RST_SKIP_A_START  = 32'h8010_0000;
    localparam logic [32:0] RST_SKIP_A_END    = 33'h0_8020_0000;
    localparam logic [31:0] RST_SKIP_B_START  = 32'h8020_0000;
    localparam logic [32:0] RST_SKIP_B_END    = 33'h0_8030_0000;
    localparam logic [31:0] RST_SKIP_C_START  = 32'h8ECF_D000;
    localparam logic [32:0] RST_SKIP_C_END    = 33'h0_9000_0000;

    // Bytes in one scanned word.
    localparam logic [32:0] WORD_BYTES = 33'd4;

endpackage

/* hw/rtl/marker_run_scanner.sv */
// Marker run scanner.
// Input channel (i_in_valid / o_in_ready) takes one memory word per request:
// its byte address, the value read there and a flag on the last word of the
// scan. Output channel (o_out_valid / i_out_ready) returns a result request
// when a run of marker words long enough to report closes, and always once
// for the last word, with o_scan_done set and o_marker_found telling whether
// any run was reported in the scan.
// An accepted word waits in the input register, and its result is loaded
// into the result register when the stage advances.
// Throughput: one word per cycle unless the receiver stalls; the per-word
// work is three window compares, one value compare and one 32-bit subtract
// with a length compare, all in the single stage between the two registers.
// Reset clears the run state and loads the default marker, minimum length
// and skip windows. Configuration writes (i_cfg_wr_en) take effect at once;
// the user must make them only while the scanner is idle; the block does not enforce this.
// When the receiver stalls, the result register holds and the input register
// stalls behind it; a word is still taken in any cycle where the input
// register is empty or drains.
module marker_run_scanner
    import mrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  t_cfg_idx    i_cfg_index,
    input  logic [32:0] i_cfg_data,
    // Word input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_word_address,
    input  logic [31:0] i_word_value,
    input  logic        i_final_word,
    // Result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_range_valid,
    output logic [31:0] o_run_first_address,
    output logic [31:0] o_run_last_address,
    output logic [32:0] o_run_length_bytes,
    output logic        o_scan_done,
    output logic        o_marker_found
);

    // Configuration registers.
    logic [31:0] r_marker_value;
    logic [32:0] r_min_run_bytes;
    logic [31:0] r_skip_a_start;
    logic [32:0] r_skip_a_end;
    logic [31:0] r_skip_b_start;
    logic [32:0] r_skip_b_end;
    logic [31:0] r_skip_c_start;
    logic [32:0] r_skip_c_end;

    // Input register.
    logic        r_in_valid;
    logic [31:0] r_addr;
    logic [31:0] r_value;
    logic        r_last;

    // Run state.
    logic        r_run_open;
    logic [31:0] r_run_start;
    logic [31:0] r_run_end;
    logic        r_any_found;

    // Result register.
    logic        r_out_valid;
    logic        r_range_valid;
    logic [31:0] r_first;
    logic [31:0] r_last_addr;
    logic [32:0] r_length;
    logic        r_done;
    logic        r_found;

    logic        out_free;
    logic        advance;
    logic        in_take;
    logic [32:0] addr_ext;
    logic        skip;
    logic        match;
    logic        eff_open;
    logic [31:0] eff_start;
    logic [31:0] eff_end;
    logic        closing;
    logic [32:0] run_len;
    logic        hit;
    logic        any_next;
    logic        emit;
    logic        n_run_open;
    logic        n_any_found;

    // Handshake: the stage advances when the input register holds a word and the result register can take a value.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // Configuration writes; unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_value  <= RST_MARKER_VALUE;
            r_min_run_bytes <= RST_MIN_RUN_BYTES;
            r_skip_a_start  <= RST_SKIP_A_START;
            r_skip_a_end    <= RST_SKIP_A_END;
            r_skip_b_start  <= RST_SKIP_B_START;
            r_skip_b_end    <= RST_SKIP_B_END;
            r_skip_c_start  <= RST_SKIP_C_START;
            r_skip_c_end    <= RST_SKIP_C_END;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MARKER_VALUE:  r_marker_value  <= i_cfg_data[31:0];
                CFG_MIN_RUN_BYTES: r_min_run_bytes <= i_cfg_data;
                CFG_SKIP_A_START:  r_skip_a_start  <= i_cfg_data[31:0];
                CFG_SKIP_A_END:    r_skip_a_end    <= i_cfg_data;
                CFG_SKIP_B_START:  r_skip_b_start  <= i_cfg_data[31:0];
                CFG_SKIP_B_END:    r_skip_b_end    <= i_cfg_data;
                CFG_SKIP_C_START:  r_skip_c_start  <= i_cfg_data[31:0];
                CFG_SKIP_C_END:    r_skip_c_end    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr  <= i_word_address;
            r_value <= i_word_value;
            r_last  <= i_final_word;
        end
    end

    // Window and marker tests. An empty or inverted window matches nothing.
    always_comb begin
        addr_ext = {1'b0, r_addr};
        skip = (addr_ext >= {1'b0, r_skip_a_start} && addr_ext < r_skip_a_end) ||
               (addr_ext >= {1'b0, r_skip_b_start} && addr_ext < r_skip_b_end) ||
               (addr_ext >= {1'b0, r_skip_c_start} && addr_ext < r_skip_c_end);
        match = !skip && (r_value == r_marker_value);
    end

    // Run update and close. A matching last word extends the run before the flush.
    always_comb begin
        if (match) begin
            eff_open  = 1'b1;
            eff_start = r_run_open ? r_run_start : r_addr;
            eff_end   = r_addr;
            closing   = r_last;
        end else begin
            eff_open  = r_run_open;
            eff_start = r_run_start;
            eff_end   = r_run_end;
            closing   = 1'b1;
        end
        run_len  = {1'b0, eff_end - eff_start} + WORD_BYTES;
        hit      = closing && eff_open && (run_len >= r_min_run_bytes);
        any_next = r_any_found || hit;
        emit     = hit || r_last;

        if (r_last) begin
            n_run_open  = 1'b0;
            n_any_found = 1'b0;
        end else begin
            n_run_open  = match;
            n_any_found = any_next;
        end
    end

    // Run state control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_any_found <= 1'b0;
            r_run_start <= '0;
            r_run_end   <= '0;
        end else if (advance) begin
            r_run_open  <= n_run_open;
            r_any_found <= n_any_found;
            if (match) begin
                r_run_start <= eff_start;
                r_run_end   <= eff_end;
            end
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    // Result register payload; range fields read zero when no run is reported.
    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_range_valid <= hit;
            r_first       <= hit ? eff_start : '0;
            r_last_addr   <= hit ? eff_end : '0;
            r_length      <= hit ? run_len : '0;
            r_done        <= r_last;
            r_found       <= any_next;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_range_valid       = r_range_valid;
    assign o_run_first_address = r_first;
    assign o_run_last_address  = r_last_addr;
    assign o_run_length_bytes  = r_length;
    assign o_scan_done         = r_done;
    assign o_marker_found      = r_found;

    // A reported run always sets the found status of the scan.
    a_found_on_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_valid) |-> o_marker_found)
        else $error("reported run without found status");

    // A result with no run is only ever the end-of-scan result.
    a_result_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_valid) |-> (o_scan_done && o_run_length_bytes == '0))
        else $error("result without run or scan end");

    // The reported length matches the reported addresses.
    a_length_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_valid) |->
        (o_run_length_bytes ==
         {1'b0, o_run_last_address - o_run_first_address} + WORD_BYTES))
        else $error("run length does not match run addresses");

    // After a scan-end word passes the stage, the run state is cleared.
    a_scan_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last) |=> (!r_run_open && !r_any_found))
        else $error("run state not cleared at end of scan");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import mrs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 137;
    localparam logic [32:0] TOP_OF_SPACE = 33'h1_0000_0000;

    // One result request as the scanner presents it.
    typedef struct packed {
        logic        range_valid;
        logic [31:0] first_addr;
        logic [31:0] last_addr;
        logic [32:0] length;
        logic        done;
        logic        found;
    } t_scan_report;

    // Tracks the open marker run and the register contents, and keeps the
    // reports that accepted words have made due, oldest first.
    class run_ledger;
        logic [31:0]  marker;
        logic [32:0]  min_run;
        logic [31:0]  win_lo [3];
        logic [32:0]  win_hi [3];
        bit           run_open;
        bit           any_found;
        logic [31:0]  run_first;
        logic [31:0]  run_last;
        t_scan_report due [$];
        int           bad_count;

        function new();
            marker    = RST_MARKER_VALUE;
            min_run   = RST_MIN_RUN_BYTES;
            win_lo[0] = RST_SKIP_A_START;
            win_hi[0] = RST_SKIP_A_END;
            win_lo[1] = RST_SKIP_B_START;
            win_hi[1] = RST_SKIP_B_END;
            win_lo[2] = RST_SKIP_C_START;
            win_hi[2] = RST_SKIP_C_END;
            run_open  = 1'b0;
            any_found = 1'b0;
            run_first = '0;
            run_last  = '0;
            bad_count = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [32:0] data);
            case (idx)
                CFG_MARKER_VALUE:  marker    = data[31:0];
                CFG_MIN_RUN_BYTES: min_run   = data;
                CFG_SKIP_A_START:  win_lo[0] = data[31:0];
                CFG_SKIP_A_END:    win_hi[0] = data;
                CFG_SKIP_B_START:  win_lo[1] = data[31:0];
                CFG_SKIP_B_END:    win_hi[1] = data;
                CFG_SKIP_C_START:  win_lo[2] = data[31:0];
                CFG_SKIP_C_END:    win_hi[2] = data;
                default: ;
            endcase
        endfunction

        function void report(string what, logic [32:0] got, logic [32:0] want);
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
            bad_count++;
        endfunction

        // Closes the open run and fills in the range if it is long enough.
        function bit close_run(inout t_scan_report r);
            logic [32:0] len;
            if (!run_open) begin
                return 1'b0;
            end
            run_open = 1'b0;
            len = {1'b0, run_last - run_first} + WORD_BYTES;
            if (len < min_run) begin
                return 1'b0;
            end
            r.range_valid = 1'b1;
            r.first_addr  = run_first;
            r.last_addr   = run_last;
            r.length      = len;
            any_found     = 1'b1;
            return 1'b1;
        endfunction

        // Called for every accepted word request.
        function void take_word(logic [31:0] addr, logic [31:0] value, logic last);
            t_scan_report r;
            bit           hit;
            bit           skip;
            r    = '0;
            skip = 1'b0;
            foreach (win_lo[w]) begin
                if ({1'b0, addr} >= {1'b0, win_lo[w]} && {1'b0, addr} < win_hi[w]) begin
                    skip = 1'b1;
                end
            end
            if (!skip && value == marker) begin
                if (!run_open) begin
                    run_open  = 1'b1;
                    run_first = addr;
                end
                run_last = addr;
                hit      = 1'b0;
            end else begin
                hit = close_run(r);
            end
            if (last) begin
                if (close_run(r)) begin
                    hit = 1'b1;
                end
                r.done = 1'b1;
            end
            r.found = any_found;
            if (hit || last) begin
                due.push_back(r);
            end
            if (last) begin
                run_open  = 1'b0;
                any_found = 1'b0;
            end
        endfunction

        // Called for every accepted result request.
        function void match_report(t_scan_report got);
            t_scan_report want;
            if (due.size() == 0) begin
                report("result with none due", got.length, '0);
                return;
            end
            want = due.pop_front();
            if (got.range_valid !== want.range_valid)
                report("range_valid", got.range_valid, want.range_valid);
            if (got.first_addr !== want.first_addr)
                report("run_first_address", got.first_addr, want.first_addr);
            if (got.last_addr !== want.last_addr)
                report("run_last_address", got.last_addr, want.last_addr);
            if (got.length !== want.length)
                report("run_length_bytes", got.length, want.length);
            if (got.done !== want.done)
                report("scan_done", got.done, want.done);
            if (got.found !== want.found)
                report("marker_found", got.found, want.found);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_MARKER_VALUE;
    logic [32:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_word_address = '0;
    logic [31:0] i_word_value = '0;
    logic        i_final_word = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_range_valid;
    logic [31:0] o_run_first_address;
    logic [31:0] o_run_last_address;
    logic [32:0] o_run_length_bytes;
    logic        o_scan_done;
    logic        o_marker_found;

    run_ledger ledger = new();
    bit        idle_on = 1'b1;
    int        cycles = 0;

    marker_run_scanner i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Give up when the run takes far longer than any correct one could.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Check each accepted result, then choose whether to stall the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            ledger.match_report({o_range_valid, o_run_first_address, o_run_last_address,
                                 o_run_length_bytes, o_scan_done, o_marker_found});
        end
        i_out_ready <= !idle_on || ($urandom_range(0, 99) >= 20);
    end

    // Offer one word request, at times after a random gap, and hold it until taken.
    task automatic send_word(logic [31:0] addr, logic [31:0] value, logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_word_address <= addr;
        i_word_value   <= value;
        i_final_word   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.take_word(addr, value, last);
    endtask

    // Stop offering words and wait until every due report has come back and
    // any word that makes no report has left the pipeline.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [32:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        ledger.write_reg(idx, data);
    endtask

    task automatic set_windows(logic [31:0] a_lo, logic [32:0] a_hi, logic [31:0] b_lo,
                               logic [32:0] b_hi, logic [31:0] c_lo, logic [32:0] c_hi);
        write_reg(CFG_SKIP_A_START, {1'b0, a_lo});
        write_reg(CFG_SKIP_A_END, a_hi);
        write_reg(CFG_SKIP_B_START, {1'b0, b_lo});
        write_reg(CFG_SKIP_B_END, b_hi);
        write_reg(CFG_SKIP_C_START, {1'b0, c_lo});
        write_reg(CFG_SKIP_C_END, c_hi);
    endtask

    // A write to an index past the last register must change nothing.
    task automatic write_unused();
        write_reg(t_cfg_idx'(CFG_SKIP_C_END + 1 + $urandom_range(0, 7)),
                  {1'($urandom), $urandom});
    endtask

    // Random settings with all three windows placed near the scanned area.
    task automatic random_setup(logic [31:0] base);
        logic [31:0] lo [3];
        logic [32:0] hi [3];
        logic [31:0] mark;
        logic [32:0] min_len;
        case ($urandom_range(0, 3))
            0: mark = $urandom;
            1: mark = '0;
            2: mark = '1;
            default: mark = RST_MARKER_VALUE;
        endcase
        case ($urandom_range(0, 5))
            0: min_len = WORD_BYTES;
            4: min_len = TOP_OF_SPACE;
            5: min_len = 33'($urandom_range(4, 40));
            default: min_len = 33'(4 * $urandom_range(1, 12));
        endcase
        foreach (lo[w]) begin
            lo[w] = base + 32'(4 * $urandom_range(0, 60));
            case ($urandom_range(0, 4))
                3: hi[w] = {1'b0, lo[w]} - 33'(4 * $urandom_range(0, 4));
                4: hi[w] = TOP_OF_SPACE;
                default: hi[w] = {1'b0, lo[w]} + 33'(4 * $urandom_range(1, 12));
            endcase
            if (hi[w] > TOP_OF_SPACE) begin
                hi[w] = TOP_OF_SPACE;
            end
        end
        write_reg(CFG_MARKER_VALUE, {1'b0, mark});
        write_reg(CFG_MIN_RUN_BYTES, min_len);
        set_windows(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
        if ($urandom_range(0, 2) == 0) begin
            write_unused();
        end
    endtask

    // Whole scans of mostly ascending words, mostly holding the marker.
    task automatic random_scans(logic [31:0] base);
        int          sent;
        int          len;
        int          pick;
        logic [31:0] cursor;
        logic [31:0] addr;
        logic [31:0] value;
        sent = 0;
        while (sent < PHASE_WORDS) begin
            len    = $urandom_range(1, 50);
            cursor = base + 32'(4 * $urandom_range(0, 16));
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    value = ledger.marker;
                else if (pick < 85)
                    value = ledger.marker ^ (32'd1 << $urandom_range(0, 31));
                else
                    value = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 90)
                    addr = cursor;
                else if (pick < 95)
                    addr = base + 32'(4 * $urandom_range(0, 80));
                else if (pick < 98)
                    addr = $urandom;
                else
                    addr = cursor - 32'd8;
                send_word(addr, value, k == len - 1);
                cursor = addr + 32'd4;
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] base;
        logic [31:0] mark;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Settings after reset: window edges, a short run that is never
        // long enough, and a scan that ends with nothing found.
        mark = RST_MARKER_VALUE;
        send_word(32'h8010_0000, mark, 1'b0);
        send_word(32'h801F_FFFC, mark, 1'b0);
        send_word(32'h8020_0000, mark, 1'b0);
        send_word(32'h8030_0000, mark, 1'b0);
        send_word(32'h8030_0004, ~mark, 1'b0);
        send_word(32'h8ECF_CFFC, mark, 1'b0);
        send_word(32'h8ECF_D000, mark, 1'b0);
        send_word(32'h8FFF_FFFC, mark, 1'b0);
        send_word(32'h9000_0000, mark, 1'b0);
        send_word(32'h9000_0004, mark, 1'b1);
        settle();

        // Zero marker, every run reported, an empty window, an inverted
        // window and one reaching the top of the address space.
        write_reg(CFG_MARKER_VALUE, '0);
        write_reg(CFG_MIN_RUN_BYTES, WORD_BYTES);
        set_windows(32'h100, 33'h100, 32'h200, 33'h100, 32'hFFFF_F000, TOP_OF_SPACE);
        send_word(32'h0, 32'h0, 1'b0);
        send_word(32'h4, 32'h0, 1'b0);
        send_word(32'h8, 32'h1, 1'b0);
        send_word(32'h100, 32'h0, 1'b0);
        send_word(32'h180, 32'h0, 1'b0);
        send_word(32'hFFFF_FFFC, 32'h0, 1'b0);
        // A descending pair wraps the length to the top value.
        send_word(32'h8, 32'h0, 1'b0);
        send_word(32'h4, 32'h0, 1'b0);
        send_word(32'hFFFF_F000, 32'h0, 1'b0);
        // Unaligned run flushed by the last word, then two one-word scans.
        send_word(32'h3, 32'h0, 1'b0);
        send_word(32'h6, 32'h0, 1'b1);
        send_word(32'h10, 32'h0, 1'b1);
        send_word(32'h20, 32'h5, 1'b1);
        settle();

        // All-ones marker, a minimum length of the whole address space, no windows at all.
        write_reg(CFG_MARKER_VALUE, 33'h0_FFFF_FFFF);
        write_reg(CFG_MIN_RUN_BYTES, TOP_OF_SPACE);
        set_windows('0, '0, '0, '0, '0, '0);
        write_unused();
        send_word(32'h8, '1, 1'b0);
        send_word(32'h4, '1, 1'b0);
        send_word(32'h0, '0, 1'b0);
        send_word(32'hFFFF_FFFC, '1, 1'b1);
        settle();

        // Random phases; the third one runs without any idling.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: base = 32'h0;
                1: base = 32'hFFFF_FF00;
                default: base = $urandom & 32'hFFFF_FFFC;
            endcase
            idle_on = (p != 2);
            random_setup(base);
            random_scans(base);
            settle();
        end

        if (ledger.bad_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/mrs_pkg.sv
hw/rtl/marker_run_scanner.sv
tb/testbench.sv
